// ----- design/pid3_pkg.sv -----
// Shared types, constants and width helpers for the three-mode PID controller.
// No dependencies; imported by pid3_update, pid_controller_three_mode_unit, pid3_checker and tb.

package pid3_pkg;

    localparam int GAIN_W         = 16;   // signed Q8.8 gains
    localparam int ACC_W          = 40;   // integral accumulator
    localparam int LIMIT_W        = 15;   // integral and output limits
    localparam int THRESH_W       = 16;   // separation threshold
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        MODE_POS = 2'd0,
        MODE_SEP = 2'd1,
        MODE_INC = 2'd2
    } t_mode;

    typedef enum logic {
        OP_STEP  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_ZERO_OUT   = 3'd1,
        REG_GAIN_P     = 3'd2,
        REG_GAIN_I     = 3'd3,
        REG_GAIN_D     = 3'd4,
        REG_INT_LIMIT  = 3'd5,
        REG_OUT_LIMIT  = 3'd6,
        REG_SEP_THRESH = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        t_mode                      mode;
        logic                       zero_output;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic [LIMIT_W-1:0]         integral_limit;
        logic [LIMIT_W-1:0]         output_limit;
        logic [THRESH_W-1:0]        sep_threshold;
    } t_pid_cfg;

    // Width of a gain times the widest error difference (e0 - 2*e1 + e2).
    function automatic int term_w(int dw);
        return GAIN_W + dw + 3;
    endfunction

    // Width that holds every sum formed before rounding, with headroom.
    function automatic int sum_w(int dw, int fb);
        int w;
        w = ACC_W;
        if (term_w(dw) > w) w = term_w(dw);
        if (dw + fb + 1 > w) w = dw + fb + 1;
        return w + 3;
    endfunction

endpackage

// ----- design/pid3_update.sv -----
// Second-stage arithmetic of the PID controller: integral update, term sum,
// rounding, clamping and saturation. Depends on pid3_pkg.

module pid3_update
    import pid3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  t_pid_cfg                                 i_cfg,
    input  logic                                     i_sep,
    input  logic signed [term_w(DATA_WIDTH)-1:0]     i_p_term,
    input  logic signed [term_w(DATA_WIDTH)-1:0]     i_i_term,
    input  logic signed [term_w(DATA_WIDTH)-1:0]     i_d_term,
    input  logic signed [ACC_W-1:0]                  i_acc,
    input  logic signed [DATA_WIDTH-1:0]             i_held,
    output logic signed [ACC_W-1:0]                  o_acc,
    output logic signed [DATA_WIDTH-1:0]             o_held
);

    localparam int SUM_W = sum_w(DATA_WIDTH, FRAC_BITS);

    localparam logic signed [SUM_W-1:0] ACC_HI  = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_LO  = ~ACC_HI;
    localparam logic signed [SUM_W-1:0] OUT_HI  =
        SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] OUT_LO  = ~OUT_HI;
    localparam logic signed [SUM_W-1:0] HALF    = SUM_W'((64'sd1 <<< FRAC_BITS) >>> 1);

    logic signed [SUM_W-1:0] p_x, i_x, d_x, acc_x, held_sc;
    logic signed [SUM_W-1:0] acc_sum, acc_sat, acc_pos, acc_n;
    logic signed [SUM_W-1:0] ilim, olim, sum, rnd, rnd_lim, rnd_sat;
    logic                    step_ok;

    always_comb begin
        p_x     = SUM_W'(i_p_term);
        i_x     = SUM_W'(i_i_term);
        d_x     = SUM_W'(i_d_term);
        acc_x   = SUM_W'(i_acc);
        held_sc = SUM_W'(i_held) <<< FRAC_BITS;

        // Accumulate and saturate to the accumulator range.
        acc_sum = acc_x + i_x;
        if (acc_sum > ACC_HI) begin
            acc_sat = ACC_HI;
        end else if (acc_sum < ACC_LO) begin
            acc_sat = ACC_LO;
        end else begin
            acc_sat = acc_sum;
        end

        // Optional integral clamp, positional mode only.
        ilim = SUM_W'(i_cfg.integral_limit) <<< FRAC_BITS;
        if (i_cfg.integral_limit == '0) begin
            acc_pos = acc_sat;
        end else if (acc_sat > ilim) begin
            acc_pos = ilim;
        end else if (acc_sat < -ilim) begin
            acc_pos = -ilim;
        end else begin
            acc_pos = acc_sat;
        end

        step_ok = 1'b1;
        unique case (i_cfg.mode)
            MODE_POS: begin
                acc_n = acc_pos;
                sum   = p_x + acc_pos + d_x;
            end
            MODE_SEP: begin
                acc_n = i_sep ? '0 : acc_sat;
                sum   = p_x + d_x + acc_n;
            end
            MODE_INC: begin
                acc_n = acc_sat;
                sum   = held_sc + p_x + i_x + d_x;
            end
            default: begin
                // Reserved mode: the step leaves all state as it was.
                step_ok = 1'b0;
                acc_n   = acc_x;
                sum     = '0;
            end
        endcase

        rnd = (sum + HALF) >>> FRAC_BITS;

        olim = SUM_W'(i_cfg.output_limit);
        if (i_cfg.output_limit == '0) begin
            rnd_lim = rnd;
        end else if (rnd > olim) begin
            rnd_lim = olim;
        end else if (rnd < -olim) begin
            rnd_lim = -olim;
        end else begin
            rnd_lim = rnd;
        end

        if (rnd_lim > OUT_HI) begin
            rnd_sat = OUT_HI;
        end else if (rnd_lim < OUT_LO) begin
            rnd_sat = OUT_LO;
        end else begin
            rnd_sat = rnd_lim;
        end

        o_acc  = acc_n[ACC_W-1:0];
        o_held = step_ok ? rnd_sat[DATA_WIDTH-1:0] : i_held;
    end

endmodule

// ----- design/pid_controller_three_mode_unit.sv -----
// Top level of the three-mode PID controller: input register, error and gain
// product stage, and the result register. Depends on pid3_pkg and pid3_update.
//
// Usage
// -----
// The input channel (i_valid, o_stall, i_op, i_setpoint, i_measurement) takes
// one transaction whenever i_valid is high and o_stall is low. A step
// transaction forms the error, updates the controller state in a defined
// mode and yields one drive value on the output channel (o_valid, i_stall,
// o_drive). A clear transaction zeroes the error history, the integral and
// the held output and yields nothing on the output channel.
//
// The pipeline has three registers: the input register, the product register
// (error history and the three gain products are settled here) and the
// result register, through which a drive value moves in that order. While
// the receiver does not stall, a new transaction can be accepted on every
// cycle, so the throughput is one transaction per cycle. The integral and
// held-output feedback closes inside the second stage.
//
// When the receiver stalls, the result register holds its value and each
// stage keeps accepting until it is full; o_stall rises only once all three
// stages hold a transaction. The configuration port is a plain write port and
// must only be used while no transaction is in flight. Synchronous reset
// clears every configuration register, the controller state and all valid
// flags.

module pid_controller_three_mode_unit
    import pid3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // Input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic signed [DATA_WIDTH-1:0]  i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]  i_measurement,
    // Output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DATA_WIDTH-1:0]  o_drive
);

    localparam int EW     = DATA_WIDTH + 1;        // error width
    localparam int OW     = EW + 2;                // multiplier operand width
    localparam int TERM_W = term_w(DATA_WIDTH);
    localparam int CMP_W  = (EW > THRESH_W) ? EW : THRESH_W;
    localparam int LW     = ((DATA_WIDTH > LIMIT_W) ? DATA_WIDTH : LIMIT_W) + 1;

    // Configuration registers.
    t_pid_cfg r_cfg;

    // Input register.
    logic                         r_v1;
    t_op                          r_op1;
    logic signed [DATA_WIDTH-1:0] r_sp1, r_meas1;

    // Error history.
    logic signed [EW-1:0]         r_err_now, r_err_prev;

    // Product register.
    logic                         r_v2;
    t_op                          r_op2;
    logic                         r_sep2;
    logic signed [TERM_W-1:0]     r_p2, r_i2, r_d2;

    // Controller state and result register.
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [DATA_WIDTH-1:0] r_held;
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_drive;

    // Handshake and flow control.
    logic in_acc, out_free, adv1, adv2, s1_free, s2_free;

    // First-stage arithmetic.
    logic signed [EW-1:0]     err;
    logic signed [EW:0]       d1;
    logic signed [OW-1:0]     d2, p_opnd, d_opnd;
    logic [EW-1:0]            mag;
    logic                     sep;
    logic signed [TERM_W-1:0] p_term, i_term, d_term;
    logic                     mode_ok;

    // Second-stage results.
    logic signed [ACC_W-1:0]      acc_n;
    logic signed [DATA_WIDTH-1:0] held_n;

    // Flow control: a stage may advance when the one after it is free or
    // frees itself in this same cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign adv2     = r_v2 && out_free;
    assign s2_free  = !r_v2 || adv2;
    assign adv1     = r_v1 && s2_free;
    assign s1_free  = !r_v1 || adv1;
    assign o_stall  = !s1_free;
    assign in_acc   = i_valid && s1_free;

    assign mode_ok = (r_cfg.mode == MODE_POS) || (r_cfg.mode == MODE_SEP) ||
                     (r_cfg.mode == MODE_INC);

    // Error, its differences against the history, and the gain products.
    // Incremental mode takes the first difference for P and the second
    // difference for D; the positional modes take the error and the first
    // difference.
    always_comb begin
        err    = EW'(r_sp1) - EW'(r_meas1);
        d1     = (EW + 1)'(err) - (EW + 1)'(r_err_now);
        d2     = OW'(err) - (OW'(r_err_now) <<< 1) + OW'(r_err_prev);
        p_opnd = (r_cfg.mode == MODE_INC) ? OW'(d1) : OW'(err);
        d_opnd = (r_cfg.mode == MODE_INC) ? d2 : OW'(d1);
        p_term = TERM_W'($signed(r_cfg.gain_p)) * TERM_W'(p_opnd);
        i_term = TERM_W'($signed(r_cfg.gain_i)) * TERM_W'(err);
        d_term = TERM_W'($signed(r_cfg.gain_d)) * TERM_W'(d_opnd);
        mag    = err[EW-1] ? EW'(-err) : EW'(err);
        sep    = CMP_W'(mag) > CMP_W'(r_cfg.sep_threshold);
    end

    pid3_update #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_update (
        .i_cfg    (r_cfg),
        .i_sep    (r_sep2),
        .i_p_term (r_p2),
        .i_i_term (r_i2),
        .i_d_term (r_d2),
        .i_acc    (r_acc),
        .i_held   (r_held),
        .o_acc    (acc_n),
        .o_held   (held_n)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_MODE:       r_cfg.mode           <= t_mode'(i_cfg_data[1:0]);
                REG_ZERO_OUT:   r_cfg.zero_output    <= i_cfg_data[0];
                REG_GAIN_P:     r_cfg.gain_p         <= i_cfg_data;
                REG_GAIN_I:     r_cfg.gain_i         <= i_cfg_data;
                REG_GAIN_D:     r_cfg.gain_d         <= i_cfg_data;
                REG_INT_LIMIT:  r_cfg.integral_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_OUT_LIMIT:  r_cfg.output_limit   <= i_cfg_data[LIMIT_W-1:0];
                REG_SEP_THRESH: r_cfg.sep_threshold  <= i_cfg_data[THRESH_W-1:0];
            endcase
        end
    end

    // Valid flags and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_err_now   <= '0;
            r_err_prev  <= '0;
            r_acc       <= '0;
            r_held      <= '0;
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end

            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end

            if (adv2 && r_op2 == OP_STEP) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            // The error history shifts only for a step in a defined mode.
            if (adv1) begin
                if (r_op1 == OP_CLEAR) begin
                    r_err_now  <= '0;
                    r_err_prev <= '0;
                end else if (mode_ok) begin
                    r_err_prev <= r_err_now;
                    r_err_now  <= err;
                end
            end

            if (adv2) begin
                if (r_op2 == OP_CLEAR) begin
                    r_acc  <= '0;
                    r_held <= '0;
                end else begin
                    r_acc  <= acc_n;
                    r_held <= held_n;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op1   <= t_op'(i_op);
            r_sp1   <= i_setpoint;
            r_meas1 <= i_measurement;
        end
        if (adv1) begin
            r_op2  <= r_op1;
            r_sep2 <= sep;
            r_p2   <= p_term;
            r_i2   <= i_term;
            r_d2   <= d_term;
        end
        if (adv2 && r_op2 == OP_STEP) begin
            r_drive <= r_cfg.zero_output ? '0 : held_n;
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    // Checks on the held output against the output limit.
    logic signed [LW-1:0] a_held, a_lim;
    logic                 a_step2;

    assign a_held  = LW'(r_held);
    assign a_lim   = LW'(r_cfg.output_limit);
    assign a_step2 = adv2 && (r_op2 == OP_STEP);

    // A clear transaction leaves the integral and the held output at zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && r_op2 == OP_CLEAR) |=> (r_acc == '0 && r_held == '0))
        else $error("clear transaction did not zero the controller state");

    // A new result appears only from a step transaction leaving stage two.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(a_step2))
        else $error("result register loaded without a step transaction");

    // In the reserved mode a step leaves the held output untouched.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_step2 && !mode_ok) |=> $stable(r_held))
        else $error("reserved mode changed the held output");

    // In a defined mode, a non-zero output limit bounds the held output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_step2 && mode_ok && r_cfg.output_limit != '0) |=>
            (a_held <= a_lim && a_held >= -a_lim))
        else $error("held output outside the output limit");

endmodule

// ----- tb/pid3_checker.sv -----
// Transaction checker for the three-mode PID controller: mirrors the register
// writes, predicts every drive value and compares it with the output channel.
// Depends on pid3_pkg only.

module pid3_checker
    import pid3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_op,
    input  logic signed [DATA_WIDTH-1:0]  i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]  i_measurement,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [DATA_WIDTH-1:0]  i_drive,
    output int                            o_mismatches,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ACC_MAX    = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint ACC_MIN    = -ACC_MAX - 1;
    localparam longint OUT_MAX    = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;
    localparam longint FRAC_SCALE = 64'sd1 <<< FRAC_BITS;
    localparam longint ROUND_HALF = FRAC_SCALE >>> 1;

    // Mirrored registers.
    logic [1:0]                 mode_r;
    logic                       zero_r;
    logic signed [GAIN_W-1:0]   kp_r, ki_r, kd_r;
    logic [LIMIT_W-1:0]         ilim_r, olim_r;
    logic [THRESH_W-1:0]        thr_r;

    // Controller state.
    logic signed [DATA_WIDTH:0]   err_now, err_prev, err_prev2;
    logic signed [ACC_W-1:0]      integ;
    logic signed [DATA_WIDTH-1:0] held_drive;

    logic signed [DATA_WIDTH-1:0] drive_expected [$];
    int mismatches;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_history();
        err_now    = '0;
        err_prev   = '0;
        err_prev2  = '0;
        integ      = '0;
        held_drive = '0;
    endfunction

    // One control step; returns the drive value that the step reports.
    function automatic logic signed [DATA_WIDTH-1:0] advance_pid_state(
        logic signed [DATA_WIDTH-1:0] sp,
        logic signed [DATA_WIDTH-1:0] ms
    );
        longint e0, e1, e2, kp, ki, kd, acc, sum, res, lim, thr;
        if (mode_r inside {MODE_POS, MODE_SEP, MODE_INC}) begin
            e0 = longint'(sp) - longint'(ms);
            err_prev2 = err_prev;
            err_prev  = err_now;
            err_now   = e0[DATA_WIDTH:0];
            e1 = longint'(err_prev);
            e2 = longint'(err_prev2);
            kp = longint'(kp_r);
            ki = longint'(ki_r);
            kd = longint'(kd_r);
            acc = clip(longint'(integ) + ki * e0, ACC_MIN, ACC_MAX);
            case (mode_r)
                MODE_POS: begin
                    if (ilim_r != '0) begin
                        lim = longint'(ilim_r);
                        lim = lim * FRAC_SCALE;
                        acc = clip(acc, -lim, lim);
                    end
                    sum = kp * e0 + acc + kd * (e0 - e1);
                end
                MODE_SEP: begin
                    thr = longint'(thr_r);
                    sum = kp * e0 + kd * (e0 - e1);
                    if ((e0 < 0 ? -e0 : e0) > thr)
                        acc = 0;
                    else
                        sum = sum + acc;
                end
                default: begin
                    // Incremental: the integral keeps accumulating but only the
                    // increment is added to the held output.
                    sum = longint'(held_drive) * FRAC_SCALE + kp * (e0 - e1) + ki * e0
                        + kd * (e0 - 2 * e1 + e2);
                end
            endcase
            res = (sum + ROUND_HALF) >>> FRAC_BITS;
            if (olim_r != '0) begin
                lim = longint'(olim_r);
                res = clip(res, -lim, lim);
            end
            held_drive = DATA_WIDTH'(clip(res, OUT_MIN, OUT_MAX));
            integ = ACC_W'(acc);
        end
        return zero_r ? '0 : held_drive;
    endfunction

    task automatic report_failure(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] drive check failed: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : watch
        logic signed [DATA_WIDTH-1:0] want;
        if (!i_rst_n) begin
            mode_r = MODE_POS;
            zero_r = 1'b0;
            kp_r   = '0;
            ki_r   = '0;
            kd_r   = '0;
            ilim_r = '0;
            olim_r = '0;
            thr_r  = '0;
            clear_history();
            drive_expected.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (drive_expected.size() == 0) begin
                    report_failure($sformatf("drive %0d with nothing outstanding", i_drive));
                end else begin
                    want = drive_expected.pop_front();
                    if (i_drive !== want)
                        report_failure($sformatf("expected %0d, got %0d", want, i_drive));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_CLEAR)
                    clear_history();
                else
                    drive_expected.push_back(advance_pid_state(i_setpoint, i_measurement));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:       mode_r = i_cfg_data[1:0];
                    REG_ZERO_OUT:   zero_r = i_cfg_data[0];
                    REG_GAIN_P:     kp_r   = i_cfg_data;
                    REG_GAIN_I:     ki_r   = i_cfg_data;
                    REG_GAIN_D:     kd_r   = i_cfg_data;
                    REG_INT_LIMIT:  ilim_r = i_cfg_data[LIMIT_W-1:0];
                    REG_OUT_LIMIT:  olim_r = i_cfg_data[LIMIT_W-1:0];
                    REG_SEP_THRESH: thr_r  = i_cfg_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= drive_expected.size();
    end

endmodule

// ----- tb/tb.sv -----
// Top of the three-mode PID controller testbench: clock, reset, register
// programming, input stimulus and receiver back-pressure, plus the verdict.
// Depends on pid3_pkg, pid_controller_three_mode_unit and pid3_checker.

module tb
    import pid3_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW             = DATA_WIDTH_DEF;
    localparam int STEP_TARGET    = 1350;     // input transactions to offer
    localparam int RX_HOLD_CYCLES = 64;       // long receiver hold-off
    localparam int DRAIN_CYCLES   = 6;        // covers the pipeline registers and slack
    localparam int CYCLE_LIMIT    = 1000000;

    // Mode value 3 has no meaning; the block must ignore steps while it is set.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    i_valid       = 1'b0;
    logic                    i_op          = OP_STEP;
    logic signed [DW-1:0]    i_setpoint    = '0;
    logic signed [DW-1:0]    i_measurement = '0;
    logic                    i_stall       = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic signed [DW-1:0]    o_drive;

    int mismatch_total;
    int drives_pending;

    // Register images written by the programming task, indexed by register.
    logic [CFG_DATA_W-1:0] reg_val [8];

    // When set, the sender offers transactions back to back.
    bit gapless;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_request;
    int items_sent;
    int cycle_count;

    pid_controller_three_mode_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_setpoint    (i_setpoint),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive       (o_drive)
    );

    pid3_checker #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS_DEF)) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_op          (i_op),
        .i_setpoint    (i_setpoint),
        .i_measurement (i_measurement),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_drive       (o_drive),
        .o_mismatches  (mismatch_total),
        .o_pending     (drives_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every task below is entered just after a rising edge and returns just
    // after one, so all driving happens with nonblocking assignments at the edge.

    // Sender gap before a transaction: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Setpoint or measurement: extremes, small values near zero, or anything.
    function automatic logic signed [DW-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) begin
            case ($urandom_range(0, 4))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'sh0001;
                default: return 16'shffff;
            endcase
        end
        if (r < 12) return DW'($urandom_range(0, 400) - 200);
        return DW'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'h0100;
            endcase
        end
        if (r < 6) return CFG_DATA_W'($urandom_range(0, 1024) - 512);
        return CFG_DATA_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return '0;
        if (r == 2) return CFG_DATA_W'(32767);
        if (r < 7) return CFG_DATA_W'($urandom_range(1, 2000));
        return CFG_DATA_W'($urandom_range(0, 32767));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 16'hffff;
        if (r < 7) return CFG_DATA_W'($urandom_range(0, 3000));
        return CFG_DATA_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [1:0] pick_mode();
        if ($urandom_range(0, 19) == 0) return MODE_SPARE;
        case ($urandom_range(0, 2))
            0: return MODE_POS;
            1: return MODE_SEP;
            default: return MODE_INC;
        endcase
    endfunction

    // Writes each register whose mask bit is set, one per clock edge.
    task automatic write_regs(input logic [7:0] mask);
        for (int r = 0; r < 8; r++) begin
            if (mask[r]) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= CFG_IDX_W'(r);
                i_cfg_data  <= reg_val[r];
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(
        input logic [1:0]            mode,
        input logic                  zero,
        input logic [CFG_DATA_W-1:0] kp,
        input logic [CFG_DATA_W-1:0] ki,
        input logic [CFG_DATA_W-1:0] kd,
        input logic [CFG_DATA_W-1:0] ilim,
        input logic [CFG_DATA_W-1:0] olim,
        input logic [CFG_DATA_W-1:0] thr
    );
        reg_val[REG_MODE]       = CFG_DATA_W'(mode);
        reg_val[REG_ZERO_OUT]   = CFG_DATA_W'(zero);
        reg_val[REG_GAIN_P]     = kp;
        reg_val[REG_GAIN_I]     = ki;
        reg_val[REG_GAIN_D]     = kd;
        reg_val[REG_INT_LIMIT]  = ilim;
        reg_val[REG_OUT_LIMIT]  = olim;
        reg_val[REG_SEP_THRESH] = thr;
        write_regs(8'hff);
    endtask

    // Offers one transaction after a random gap and returns once it is taken.
    // Valid is left high, so a following transaction with no gap is offered
    // on the very next edge without the valid line dropping.
    task automatic send_item(
        input logic                 op,
        input logic signed [DW-1:0] sp,
        input logic signed [DW-1:0] ms
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_setpoint    <= sp;
        i_measurement <= ms;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Lets everything drain. A clear transaction yields no drive value, so the
    // task keeps waiting after the last expected value has arrived.
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (drives_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver back-pressure: random runs of stall and no stall, occasional
    // quiet stretches, and one long hold-off on request from the stimulus.
    initial begin : receiver_side
        int  run;
        int  r;
        bit  hold;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold = 1'b1;
                run  = RX_HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    hold = 1'b0;
                    run  = $urandom_range(40, 120);
                end else if (r < 60) begin
                    hold = 1'b0;
                    run  = $urandom_range(1, 6);
                end else if (r < 95) begin
                    hold = 1'b1;
                    run  = $urandom_range(1, 3);
                end else begin
                    hold = 1'b1;
                    run  = $urandom_range(8, 25);
                end
            end
            i_stall <= hold;
            repeat (run) @(posedge i_clk);
        end
    end

    // Safety net: a hung handshake ends the run as a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int burst;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Positional mode: the largest errors of both signs, a repeated large
        // error that drives the integral into its clamp, and a clear transaction.
        load_settings(MODE_POS, 1'b0, 16'h0180, 16'h0040, 16'h0020, 16'd100, 16'd0,
                      16'd1000);
        send_item(OP_STEP, 0, 0);
        send_item(OP_STEP, 32767, -32768);
        send_item(OP_STEP, -32768, 32767);
        send_item(OP_STEP, 32767, -32768);
        send_item(OP_STEP, 32767, -32768);
        send_item(OP_CLEAR, 1234, -4321);
        send_item(OP_STEP, -5, 3);
        settle();

        // Separation mode: error exactly at the threshold keeps the integral,
        // just above it clears the integral, on both signs.
        load_settings(MODE_SEP, 1'b0, 16'h0180, 16'h0040, 16'h0020, 16'd100, 16'd2000,
                      16'd1000);
        send_item(OP_STEP, 1000, 0);
        send_item(OP_STEP, 0, -1001);
        send_item(OP_STEP, -1001, 0);
        send_item(OP_STEP, -500, 500);
        settle();

        // Incremental mode with extreme gains, so the held output saturates.
        load_settings(MODE_INC, 1'b0, 16'h7fff, 16'h8000, 16'h7fff, 16'd0, 16'd0, 16'd0);
        send_item(OP_STEP, 100, 0);
        send_item(OP_STEP, -32768, 32767);
        send_item(OP_STEP, 32767, -32768);
        send_item(OP_STEP, 0, 0);
        settle();

        // Incremental mode with an output clamp.
        load_settings(MODE_INC, 1'b0, 16'h0100, 16'h0080, 16'h0000, 16'd0, 16'd500, 16'd0);
        send_item(OP_STEP, 300, 0);
        send_item(OP_STEP, -300, 0);
        settle();

        // The unused mode leaves the state alone; first with a forced zero drive.
        load_settings(MODE_SPARE, 1'b1, 16'h0100, 16'h0100, 16'h0100, 16'd0, 16'd0, 16'd0);
        send_item(OP_STEP, 123, -45);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_STEP, 5, 5);
        settle();
        reg_val[REG_ZERO_OUT] = '0;
        write_regs(8'h02);
        send_item(OP_STEP, 7, 0);
        settle();

        // Largest limits with negative unit gains.
        load_settings(MODE_POS, 1'b0, 16'hff00, 16'hff00, 16'hff00, 16'd32767, 16'd32767,
                      16'hffff);
        send_item(OP_STEP, -32768, 32767);
        send_item(OP_STEP, 32767, -32768);

        // Random phases: a random subset of the registers is rewritten each time, then
        // a burst of transactions, mostly control steps with the odd clear among them.
        phase = 0;
        while (items_sent < STEP_TARGET) begin
            settle();
            reg_val[REG_MODE]       = CFG_DATA_W'(pick_mode());
            reg_val[REG_ZERO_OUT]   = CFG_DATA_W'($urandom_range(0, 6) == 0);
            reg_val[REG_GAIN_P]     = pick_gain();
            reg_val[REG_GAIN_I]     = pick_gain();
            reg_val[REG_GAIN_D]     = pick_gain();
            reg_val[REG_INT_LIMIT]  = pick_limit();
            reg_val[REG_OUT_LIMIT]  = pick_limit();
            reg_val[REG_SEP_THRESH] = pick_threshold();
            write_regs(8'($urandom_range(0, 255)));
            gapless = ($urandom_range(0, 3) == 0);

            // Once, the receiver holds off for a long stretch while the sender
            // keeps offering, so the pipeline fills and the input is stalled.
            if (phase == 2) begin
                gapless = 1'b1;
                hold_request = 1'b1;
                do @(posedge i_clk); while (hold_request);
                repeat (12) send_item(OP_STEP, pick_sample(), pick_sample());
            end

            burst = $urandom_range(20, 80);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 3)
                    send_item(OP_CLEAR, pick_sample(), pick_sample());
                else
                    send_item(OP_STEP, pick_sample(), pick_sample());
            end
            phase++;
        end

        settle();
        if (mismatch_total == 0 && drives_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
